### hdl/a51_keystream_generator_unit_assert.svh
// Assertion macros for the keystream generator checker
`ifndef A51_KEYSTREAM_GENERATOR_UNIT_ASSERT_SVH
`define A51_KEYSTREAM_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define A51_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("a51 check failed");

// Next-cycle implication, disabled during reset
`define A51_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("a51 check failed");

`endif

### hdl/a51_pkg.sv
package a51_pkg;

    localparam int KEY_W        = 64;
    localparam int FRAME_W      = 22;
    localparam int LOAD_STEPS   = KEY_W + FRAME_W;
    localparam int LOAD_W       = LOAD_STEPS;

    localparam int R1_W = 19;
    localparam int R2_W = 22;
    localparam int R3_W = 23;

    localparam logic [R1_W-1:0] TAPS_ONE   = 19'h72000;
    localparam logic [R2_W-1:0] TAPS_TWO   = 22'h300000;
    localparam logic [R3_W-1:0] TAPS_THREE = 23'h700080;

    localparam int MID_ONE_BIT   = 8;
    localparam int MID_TWO_BIT   = 10;
    localparam int MID_THREE_BIT = 10;

    localparam logic [7:0] MAX_STREAM_BITS = 8'd228;
    localparam logic [7:0] LOAD_LAST_CNT   = 8'(LOAD_STEPS - 1);

    localparam logic [7:0] MIX_ROUNDS_RST  = 8'd100;
    localparam logic [7:0] STREAM_BITS_RST = 8'd114;

    // Configuration register indexes
    localparam logic [7:0] REG_MIX_ROUNDS  = 8'd0;
    localparam logic [7:0] REG_STREAM_BITS = 8'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load;
        logic mix;
        logic stream;
        logic cnt_clr;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic load_last;
        logic mix_done;
        logic stream_last;
        logic emit_block;
    } sts_t;

    function automatic logic [R1_W-1:0] shift_one(input logic [R1_W-1:0] r);
        return {r[R1_W-2:0], ^(r & TAPS_ONE)};
    endfunction

    function automatic logic [R2_W-1:0] shift_two(input logic [R2_W-1:0] r);
        return {r[R2_W-2:0], ^(r & TAPS_TWO)};
    endfunction

    function automatic logic [R3_W-1:0] shift_three(input logic [R3_W-1:0] r);
        return {r[R3_W-2:0], ^(r & TAPS_THREE)};
    endfunction

endpackage

### hdl/a51_datapath.sv
module a51_datapath
    import a51_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [KEY_W-1:0]     session_key,
    input  logic [FRAME_W-1:0]   frame_number,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [7:0]           keystream_byte,
    output logic [3:0]           valid_bits,
    output logic                 last_byte,
    output logic                 final_bit
);

    logic [7:0]        mix_rounds_reg;
    logic [7:0]        stream_bits_reg;
    logic [LOAD_W-1:0] load_sr_reg;
    logic [R1_W-1:0]   lfsr_one_reg, lfsr_one_next;
    logic [R2_W-1:0]   lfsr_two_reg, lfsr_two_next;
    logic [R3_W-1:0]   lfsr_three_reg, lfsr_three_next;
    logic [7:0]        acc_reg, acc_next;
    logic [2:0]        fill_reg, fill_next;
    logic [7:0]        cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [3:0]        out_vbits_reg;
    logic              out_last_reg;
    logic              out_final_reg;

    logic              a_bit, b_bit, c_bit, maj;
    logic [R1_W-1:0]   r1_maj;
    logic [R2_W-1:0]   r2_maj;
    logic [R3_W-1:0]   r3_maj;
    logic              ks_bit;
    logic [7:0]        byte_now;
    logic [7:0]        total_m1;
    logic              emit;
    logic              in_bit;

    // Clamp the stream length to 1..MAX_STREAM_BITS, minus one
    always_comb
    begin
        if (stream_bits_reg == 8'd0)
            total_m1 = 8'd0;
        else if (stream_bits_reg > MAX_STREAM_BITS)
            total_m1 = MAX_STREAM_BITS - 8'd1;
        else
            total_m1 = stream_bits_reg - 8'd1;
    end

    // Majority clocking and keystream bit
    always_comb
    begin
        a_bit  = lfsr_one_reg[MID_ONE_BIT];
        b_bit  = lfsr_two_reg[MID_TWO_BIT];
        c_bit  = lfsr_three_reg[MID_THREE_BIT];
        maj    = (a_bit & b_bit) | (a_bit & c_bit) | (b_bit & c_bit);
        r1_maj = (a_bit == maj) ? shift_one(lfsr_one_reg) : lfsr_one_reg;
        r2_maj = (b_bit == maj) ? shift_two(lfsr_two_reg) : lfsr_two_reg;
        r3_maj = (c_bit == maj) ? shift_three(lfsr_three_reg) : lfsr_three_reg;
        ks_bit = r1_maj[R1_W-1] ^ r2_maj[R2_W-1] ^ r3_maj[R3_W-1];
        byte_now = acc_reg | ({7'd0, ks_bit} << (3'd7 - fill_reg));
    end

    assign in_bit = load_sr_reg[0];
    assign emit   = (fill_reg == 3'd7) || (cnt_reg == total_m1);

    // Status back to the controller
    always_comb
    begin
        sts.load_last   = (cnt_reg == LOAD_LAST_CNT);
        sts.mix_done    = (cnt_reg == mix_rounds_reg);
        sts.stream_last = (cnt_reg == total_m1);
        sts.emit_block  = emit && out_valid_reg && out_stall;
    end

    // Next state of the registers
    always_comb
    begin
        lfsr_one_next   = lfsr_one_reg;
        lfsr_two_next   = lfsr_two_reg;
        lfsr_three_next = lfsr_three_reg;
        acc_next        = acc_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cmd.capture)
        begin
            lfsr_one_next   = '0;
            lfsr_two_next   = '0;
            lfsr_three_next = '0;
            acc_next        = '0;
            fill_next       = '0;
        end
        else if (cmd.load)
        begin
            lfsr_one_next   = shift_one(lfsr_one_reg) ^ {{(R1_W-1){1'b0}}, in_bit};
            lfsr_two_next   = shift_two(lfsr_two_reg) ^ {{(R2_W-1){1'b0}}, in_bit};
            lfsr_three_next = shift_three(lfsr_three_reg) ^ {{(R3_W-1){1'b0}}, in_bit};
        end
        else if (cmd.mix || cmd.stream)
        begin
            lfsr_one_next   = r1_maj;
            lfsr_two_next   = r2_maj;
            lfsr_three_next = r3_maj;
        end

        // Pack the bit; hand a finished byte to the output register
        if (cmd.stream)
        begin
            if (emit)
            begin
                acc_next       = '0;
                fill_next      = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next  = byte_now;
                fill_next = fill_reg + 3'd1;
            end
        end

        if (cmd.cnt_clr)
            cnt_next = '0;
        else if (cmd.load || cmd.mix || cmd.stream)
            cnt_next = cnt_reg + 8'd1;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_rounds_reg  <= MIX_ROUNDS_RST;
            stream_bits_reg <= STREAM_BITS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_MIX_ROUNDS:  mix_rounds_reg  <= cfg_data;
                REG_STREAM_BITS: stream_bits_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control and LFSR state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_one_reg   <= '0;
            lfsr_two_reg   <= '0;
            lfsr_three_reg <= '0;
            acc_reg        <= '0;
            fill_reg       <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            lfsr_one_reg   <= lfsr_one_next;
            lfsr_two_reg   <= lfsr_two_next;
            lfsr_three_reg <= lfsr_three_next;
            acc_reg        <= acc_next;
            fill_reg       <= fill_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Input shift line and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            load_sr_reg <= {frame_number, session_key};
        else if (cmd.load)
            load_sr_reg <= {1'b0, load_sr_reg[LOAD_W-1:1]};

        if (cmd.stream && emit)
        begin
            out_byte_reg  <= byte_now;
            out_vbits_reg <= {1'b0, fill_reg} + 4'd1;
            out_last_reg  <= sts.stream_last;
            out_final_reg <= sts.stream_last & ks_bit;
        end
    end

    assign out_valid      = out_valid_reg;
    assign keystream_byte = out_byte_reg;
    assign valid_bits     = out_vbits_reg;
    assign last_byte      = out_last_reg;
    assign final_bit      = out_final_reg;

endmodule

### hdl/a51_ctrl.sv
module a51_ctrl
    import a51_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_MIX    = 4'b0100,
        ST_STREAM = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Sequence load, mix and stream phases
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
                if (sts.load_last)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_MIX;
                end
            end
            ST_MIX:
            begin
                if (sts.mix_done)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_STREAM;
                end
                else
                    cmd.mix = 1'b1;
            end
            ST_STREAM:
            begin
                // Hold while a finished byte cannot be handed over
                if (!sts.emit_block)
                begin
                    cmd.stream = 1'b1;
                    if (sts.stream_last)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

### hdl/a51_keystream_generator_unit.sv
// Flow: a request is captured, the key and frame bits are loaded, the LFSRs are mixed,
// and then the keystream is streamed, the LFSRs clocked once per cycle unless the output stalls;
// a new request is taken only once the controller is idle again.
// Reset (rst_n, async, active low) clears LFSRs, controller and output valid;
// mix_rounds returns to 100 and stream_bits to 114.
module a51_keystream_generator_unit
    import a51_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [KEY_W-1:0]   session_key,
    input  logic [FRAME_W-1:0] frame_number,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         keystream_byte,
    output logic [3:0]         valid_bits,
    output logic               last_byte,
    output logic               final_bit,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    cmd_t cmd;
    sts_t sts;

    a51_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    a51_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .session_key    (session_key),
        .frame_number   (frame_number),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .keystream_byte (keystream_byte),
        .valid_bits     (valid_bits),
        .last_byte      (last_byte),
        .final_bit      (final_bit)
    );

endmodule

### hdl/a51_checker.sv
`include "a51_keystream_generator_unit_assert.svh"

module a51_checker
    import a51_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] keystream_byte,
    input logic [3:0] valid_bits,
    input logic       last_byte,
    input logic       final_bit
);

    // Output channel holds while stalled
    `A51_ASSERT_NEXT(out_valid_hold, out_valid && out_stall, out_valid)
    `A51_ASSERT_NEXT(out_byte_hold, out_valid && out_stall, $stable(keystream_byte))

    // Only the last byte may be partial or carry the final bit
    `A51_ASSERT_IMP(full_mid_byte, out_valid && !last_byte, valid_bits == 4'd8)
    `A51_ASSERT_IMP(final_on_last, out_valid && !last_byte, final_bit == 1'b0)

    // Busy right after a request is taken
    `A51_ASSERT_NEXT(busy_after_accept, in_valid && !in_stall, in_stall)

endmodule

bind a51_keystream_generator_unit a51_checker u_a51_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .keystream_byte (keystream_byte),
    .valid_bits     (valid_bits),
    .last_byte      (last_byte),
    .final_bit      (final_bit)
);
